### design/mhpq_pkg.sv
package mhpq_pkg;

  localparam int unsigned HeapDepthDefault = 64;

  localparam int unsigned KindW = 3;
  localparam int unsigned KeyW  = 16;
  localparam int unsigned PriW  = 16;
  localparam int unsigned StatW = 3;
  localparam int unsigned TotW  = 7;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_REDUCE = 3'd2,
    KIND_LOOKUP = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_DUP      = 3'd1;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StatW-1:0] ST_ABSENT   = 3'd3;
  localparam logic [StatW-1:0] ST_NOTLOWER = 3'd4;
  localparam logic [StatW-1:0] ST_FULL     = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_MOVE_RD,
    S_MOVE_WAIT,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_PUSH_WR,
    OP_POP_DEC,
    OP_REDUCE_WR,
    OP_LOOKUP_SET,
    OP_CLEAR,
    OP_UP_RD,
    OP_UP_SWAP,
    OP_MOVE_RD,
    OP_MOVE_WR,
    OP_DN_RD,
    OP_DN_SWAP,
    OP_TOP_RD
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [StatW-1:0] status;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic             scan_done;
    logic             scan_hit;
    logic             full;
    logic             empty;
    logic             one_left;
    logic             not_lower;
    logic             up_stop;
    logic             dn_stop;
    logic             at_root;
    logic             at_leaf;
  } stat_t;

endpackage

### design/min_heap_priority_queue_unit.sv
// throughput: one request at a time; set by the key scan, one memory read per entry,
// and the sift loop, which reads and compares one heap level at a time on the single heap memory
// the result sits in an output register; the next request is taken while it waits
// reset: asynchronous active low, empties the queue; heap memory is not cleared
module min_heap_priority_queue_unit #(
  parameter int unsigned HeapDepth = mhpq_pkg::HeapDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key[15:0], priority_req[31:16]
  input  logic [31:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // top_key[15:0], top_pri[31:16], entry_total[38:32], heap_empty[39],
  // key_found[40], found_priority[56:41], zero[63:57]
  output logic [63:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);
  import mhpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [StatW-1:0] status;
  logic [KeyW-1:0]  top_key;
  logic [PriW-1:0]  top_pri, found_pri;
  logic [TotW-1:0]  total;
  logic             heap_empty, found;
  logic             out_v_q;
  logic [63:0]      out_d_q;
  logic [2:0]       out_u_q;

  mhpq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_v_q && !m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhpq_dp #(.HeapDepth(HeapDepth)) u_dp (
    .clk_i, .rst_ni,
    .kind_i       (s_axis_tuser),
    .key_i        (s_axis_tdata[15:0]),
    .pri_i        (s_axis_tdata[31:16]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status),
    .top_key_o    (top_key),
    .top_pri_o    (top_pri),
    .total_o      (total),
    .heap_empty_o (heap_empty),
    .found_o      (found),
    .found_pri_o  (found_pri)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (cmd.out_load) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_d_q <= {7'd0, found_pri, found, heap_empty, total, top_pri, top_key};
      out_u_q <= status;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;

endmodule

### design/mhpq_ctrl.sv
module mhpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  mhpq_pkg::stat_t stat_i,
  output mhpq_pkg::cmd_t  cmd_o
);
  import mhpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = ST_OK;
    cmd_o.out_load = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN_START;
        state_d  = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        // one memory read per live entry until a hit or the end
        if (stat_i.scan_done) state_d = S_DECIDE;
        else cmd_o.op = OP_SCAN_STEP;
      end
      S_DECIDE: begin
        state_d = S_TOP_RD;
        case (stat_i.kind)
          KIND_PUSH: begin
            if (stat_i.scan_hit) cmd_o.status = ST_DUP;
            else if (stat_i.full) cmd_o.status = ST_FULL;
            else begin
              cmd_o.op = OP_PUSH_WR;
              state_d  = S_UP_RD;
            end
          end
          KIND_POP: begin
            if (stat_i.empty) cmd_o.status = ST_EMPTY;
            else begin
              cmd_o.op = OP_POP_DEC;
              if (!stat_i.one_left) state_d = S_MOVE_RD;
            end
          end
          KIND_REDUCE: begin
            if (!stat_i.scan_hit) cmd_o.status = ST_ABSENT;
            else if (stat_i.not_lower) cmd_o.status = ST_NOTLOWER;
            else begin
              cmd_o.op = OP_REDUCE_WR;
              state_d  = S_UP_RD;
            end
          end
          KIND_LOOKUP: cmd_o.op = OP_LOOKUP_SET;
          KIND_CLEAR:  cmd_o.op = OP_CLEAR;
          default: ;
        endcase
      end
      S_UP_RD: begin
        if (stat_i.at_root) state_d = S_TOP_RD;
        else begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UP_WAIT;
        end
      end
      S_UP_WAIT: state_d = S_UP_CMP;
      S_UP_CMP: begin
        if (stat_i.up_stop) state_d = S_TOP_RD;
        else begin
          cmd_o.op = OP_UP_SWAP;
          state_d  = S_UP_RD;
        end
      end
      S_MOVE_RD: begin
        cmd_o.op = OP_MOVE_RD;
        state_d  = S_MOVE_WAIT;
      end
      S_MOVE_WAIT: begin
        cmd_o.op = OP_MOVE_WR;
        state_d  = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat_i.at_leaf) state_d = S_TOP_RD;
        else begin
          cmd_o.op = OP_DN_RD;
          state_d  = S_DN_WAIT;
        end
      end
      S_DN_WAIT: state_d = S_DN_CMP;
      S_DN_CMP: begin
        if (stat_i.dn_stop) state_d = S_TOP_RD;
        else begin
          cmd_o.op = OP_DN_SWAP;
          state_d  = S_DN_RD;
        end
      end
      S_TOP_RD: begin
        cmd_o.op = OP_TOP_RD;
        state_d  = S_TOP_WAIT;
      end
      S_TOP_WAIT: state_d = S_OUT;
      S_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/mhpq_dp.sv
module mhpq_dp #(
  parameter int unsigned HeapDepth = mhpq_pkg::HeapDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mhpq_pkg::KindW-1:0]  kind_i,
  input  logic [mhpq_pkg::KeyW-1:0]   key_i,
  input  logic [mhpq_pkg::PriW-1:0]   pri_i,
  input  mhpq_pkg::cmd_t              cmd_i,
  output mhpq_pkg::stat_t             stat_o,
  output logic [mhpq_pkg::StatW-1:0]  status_o,
  output logic [mhpq_pkg::KeyW-1:0]   top_key_o,
  output logic [mhpq_pkg::PriW-1:0]   top_pri_o,
  output logic [mhpq_pkg::TotW-1:0]   total_o,
  output logic                        heap_empty_o,
  output logic                        found_o,
  output logic [mhpq_pkg::PriW-1:0]   found_pri_o
);
  import mhpq_pkg::*;

  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned CW = $clog2(HeapDepth + 1);
  localparam int unsigned EW = KeyW + PriW;

  logic [EW-1:0] mem_q [HeapDepth];
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] ra_a, ra_b;
  logic          re_a, re_b, we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic          we2;
  logic [AW-1:0] wa2;
  logic [EW-1:0] wd2;

  always_ff @(posedge clk_i) begin
    if (we)  mem_q[wa]  <= wd;
    if (we2) mem_q[wa2] <= wd2;
    if (re_a) rd_a_q <= mem_q[ra_a];
    if (re_b) rd_b_q <= mem_q[ra_b];
  end

  logic [KindW-1:0] kind_q;
  logic [KeyW-1:0]  key_q;
  logic [PriW-1:0]  pri_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             scan_v_q, scan_v_d;
  logic             hit_q, hit_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [PriW-1:0]  hit_pri_q, hit_pri_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [EW-1:0]    cur_e_q, cur_e_d;
  logic [AW-1:0]    oth_q, oth_d;
  logic [StatW-1:0] st_q, st_d;
  logic             fnd_q, fnd_d;
  logic [PriW-1:0]  fpri_q, fpri_d;

  logic [AW:0] lc, rc;
  logic [AW-1:0] par;
  logic          scan_match, scan_end;
  logic          use_r;
  logic [EW-1:0] child_e;
  logic [AW-1:0] child_i;

  assign par = AW'((cur_q - 1'b1) >> 1);
  assign lc  = {cur_q, 1'b0} + 1'b1;
  assign rc  = {cur_q, 1'b0} + 2'd2;
  assign scan_match = scan_v_q && (rd_a_q[EW-1:PriW] == key_q);
  assign scan_end   = !scan_v_q && (idx_q >= cnt_q);
  assign use_r   = ((CW+1)'(rc) < (CW+1)'(cnt_q)) && (rd_b_q[PriW-1:0] < rd_a_q[PriW-1:0]);
  assign child_e = use_r ? rd_b_q : rd_a_q;
  assign child_i = use_r ? rc[AW-1:0] : lc[AW-1:0];

  always_comb begin
    stat_o.kind      = kind_e'(kind_q);
    stat_o.scan_done = hit_q || scan_match || scan_end;
    stat_o.scan_hit  = hit_q;
    stat_o.full      = (cnt_q >= CW'(HeapDepth));
    stat_o.empty     = (cnt_q == '0);
    stat_o.one_left  = (cnt_q == CW'(1));
    stat_o.not_lower = (pri_q >= hit_pri_q);
    stat_o.up_stop   = (cur_e_q[PriW-1:0] >= rd_a_q[PriW-1:0]);
    stat_o.dn_stop   = (child_e[PriW-1:0] >= cur_e_q[PriW-1:0]);
    stat_o.at_root   = (cur_q == '0);
    stat_o.at_leaf   = ((CW+1)'(lc) >= (CW+1)'(cnt_q));
  end

  always_comb begin
    re_a = 1'b0; re_b = 1'b0; ra_a = '0; ra_b = '0;
    we = 1'b0; wa = '0; wd = '0;
    we2 = 1'b0; wa2 = '0; wd2 = '0;
    cnt_d = cnt_q; idx_d = idx_q; scan_v_d = 1'b0; hit_d = hit_q;
    pos_d = pos_q; hit_pri_d = hit_pri_q; cur_d = cur_q; cur_e_d = cur_e_q;
    oth_d = oth_q; st_d = st_q; fnd_d = fnd_q; fpri_d = fpri_q;
    if (scan_match && !hit_q) begin
      hit_d     = 1'b1;
      pos_d     = AW'(idx_q - 1'b1);
      hit_pri_d = rd_a_q[PriW-1:0];
    end
    case (cmd_i.op)
      OP_LATCH: begin
        hit_d = 1'b0; fnd_d = 1'b0; fpri_d = '0; st_d = ST_OK;
      end
      OP_SCAN_START, OP_SCAN_STEP: begin
        if (!(scan_match || hit_q) && idx_q < cnt_q) begin
          re_a = 1'b1; ra_a = idx_q[AW-1:0];
          idx_d = idx_q + 1'b1; scan_v_d = 1'b1;
        end
        if (cmd_i.op == OP_SCAN_START) begin
          hit_d = 1'b0;
          if (cnt_q != '0) begin
            re_a = 1'b1; ra_a = '0; idx_d = CW'(1); scan_v_d = 1'b1;
          end else idx_d = '0;
        end
      end
      OP_PUSH_WR: begin
        we = 1'b1; wa = cnt_q[AW-1:0]; wd = {key_q, pri_q};
        cur_d = cnt_q[AW-1:0]; cur_e_d = {key_q, pri_q};
        cnt_d = cnt_q + 1'b1;
      end
      OP_REDUCE_WR: begin
        we = 1'b1; wa = pos_q; wd = {key_q, pri_q};
        cur_d = pos_q; cur_e_d = {key_q, pri_q};
      end
      OP_POP_DEC: cnt_d = cnt_q - 1'b1;
      OP_LOOKUP_SET: begin
        fnd_d = hit_q; fpri_d = hit_q ? hit_pri_q : '0;
      end
      OP_CLEAR: cnt_d = '0;
      OP_UP_RD: begin
        re_a = 1'b1; ra_a = par; oth_d = par;
      end
      OP_UP_SWAP: begin
        we = 1'b1; wa = cur_q; wd = rd_a_q;
        we2 = 1'b1; wa2 = oth_q; wd2 = cur_e_q;
        cur_d = oth_q;
      end
      OP_MOVE_RD: begin
        re_a = 1'b1; ra_a = cnt_q[AW-1:0];
      end
      OP_MOVE_WR: begin
        we = 1'b1; wa = '0; wd = rd_a_q; cur_d = '0; cur_e_d = rd_a_q;
      end
      OP_DN_RD: begin
        re_a = 1'b1; ra_a = lc[AW-1:0];
        re_b = ((CW+1)'(rc) < (CW+1)'(cnt_q)); ra_b = rc[AW-1:0];
      end
      OP_DN_SWAP: begin
        we = 1'b1; wa = cur_q; wd = child_e;
        we2 = 1'b1; wa2 = child_i; wd2 = cur_e_q;
        cur_d = child_i;
      end
      OP_TOP_RD: begin
        re_a = 1'b1; ra_a = '0;
      end
      default: ;
    endcase
    if (cmd_i.status != ST_OK) st_d = cmd_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      scan_v_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      scan_v_q <= scan_v_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      kind_q <= kind_i; key_q <= key_i; pri_q <= pri_i;
    end
    idx_q <= idx_d; pos_q <= pos_d; hit_pri_q <= hit_pri_d;
    cur_q <= cur_d; cur_e_q <= cur_e_d; oth_q <= oth_d;
    st_q <= st_d; fnd_q <= fnd_d; fpri_q <= fpri_d;
  end

  // result fields read once the top entry is in rd_a_q
  assign status_o     = st_q;
  assign top_key_o    = (cnt_q != '0) ? rd_a_q[EW-1:PriW] : '0;
  assign top_pri_o    = (cnt_q != '0) ? rd_a_q[PriW-1:0] : '0;
  assign total_o      = TotW'(cnt_q);
  assign heap_empty_o = (cnt_q == '0);
  assign found_o      = fnd_q;
  assign found_pri_o  = fpri_q;

endmodule

### design/mhpq_checker.sv
module mhpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39] == (m_axis_tdata[38:32] == 7'd0)))
    else $error("empty flag disagrees with count");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= 3'd5)
    else $error("bad status code");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken back to back");
endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
